// File: sv/assert_macros.svh
// Assertion shorthands; expect clk and arst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every edge outside reset.
`define BGQ_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Consequent must hold after the antecedent (non-overlapping implication).
`define BGQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/bgq_pkg.sv
package bgq_pkg;

	localparam int CFG_W          = 16;
	localparam int TIMER_BITS_DEF = 16;
	localparam int TAP_W          = 4;
	localparam int APB_AW         = 4;
	localparam int APB_DW         = 32;

	localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd35;
	localparam logic [CFG_W-1:0] TAP_GAP_RST    = 16'd360;
	localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd750;
	localparam logic [TAP_W-1:0] TAP_MAX        = 4'd15;

	typedef enum logic [1:0] {
		GEST_NONE  = 2'd0,
		GEST_LONG  = 2'd1,
		GEST_BURST = 2'd2
	} gesture_t;

	typedef enum logic [1:0] {
		REG_DEBOUNCE   = 2'd0,
		REG_TAP_GAP    = 2'd1,
		REG_LONG_PRESS = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0] debounce;
		logic [CFG_W-1:0] tap_gap;
		logic [CFG_W-1:0] long_press;
	} cfg_t;

	typedef struct packed {
		gesture_t         gesture;
		logic [TAP_W-1:0] tap_total;
		logic             stable_level;
	} result_t;

endpackage

// File: sv/bgq_cfg.sv
module bgq_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [bgq_pkg::APB_AW-1:0] paddr,
	input  logic [bgq_pkg::APB_DW-1:0] pwdata,
	output logic [bgq_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	output bgq_pkg::cfg_t              cfg
);
	import bgq_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce   <= DEBOUNCE_RST;
			cfg_q.tap_gap    <= TAP_GAP_RST;
			cfg_q.long_press <= LONG_PRESS_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_DEBOUNCE:   cfg_q.debounce   <= pwdata[CFG_W-1:0];
				REG_TAP_GAP:    cfg_q.tap_gap    <= pwdata[CFG_W-1:0];
				REG_LONG_PRESS: cfg_q.long_press <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_DEBOUNCE:   prdata = APB_DW'(cfg_q.debounce);
			REG_TAP_GAP:    prdata = APB_DW'(cfg_q.tap_gap);
			REG_LONG_PRESS: prdata = APB_DW'(cfg_q.long_press);
			default:        prdata = '0;
		endcase
	end

endmodule

// File: sv/bgq_core.sv
module bgq_core #(
	parameter int TIMER_BITS = bgq_pkg::TIMER_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic              raw,
	input  bgq_pkg::cfg_t     cfg,
	output bgq_pkg::result_t  result
);
	import bgq_pkg::*;

	localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

	logic                  last_raw_q, stable_q, long_rep_q;
	logic [TAP_W-1:0]      taps_q;
	logic [TIMER_BITS-1:0] since_chg_q, since_press_q, since_tap_q;

	logic                  last_raw_n, stable_n, long_rep_n, lr_mid;
	logic [TAP_W-1:0]      taps_n, taps_mid;
	logic [TIMER_BITS-1:0] since_chg_n, since_press_n, since_tap_n;
	logic                  follow, press, tap_add, long_hit, burst;

	always_comb begin
		// elapsed counters hold at all ones
		since_chg_n   = (&since_chg_q)   ? since_chg_q   : since_chg_q + 1'b1;
		since_press_n = (&since_press_q) ? since_press_q : since_press_q + 1'b1;
		since_tap_n   = (&since_tap_q)   ? since_tap_q   : since_tap_q + 1'b1;

		last_raw_n = raw;
		if (raw != last_raw_q)
			since_chg_n = '0;

		follow   = (CMP_W'(since_chg_n) >= CMP_W'(cfg.debounce)) && (raw != stable_q);
		stable_n = follow ? raw : stable_q;
		press    = follow & raw;
		tap_add  = follow & ~raw & ~long_rep_q;

		if (press)
			since_press_n = '0;
		lr_mid = press ? 1'b0 : long_rep_q;

		taps_mid = taps_q;
		if (tap_add) begin
			if (taps_q != TAP_MAX)
				taps_mid = taps_q + 1'b1;
			since_tap_n = '0;
		end

		long_hit   = stable_n & ~lr_mid &
			(CMP_W'(since_press_n) >= CMP_W'(cfg.long_press));
		long_rep_n = lr_mid | long_hit;
		if (long_hit)
			taps_mid = '0;

		// long press empties the taps, so both events never fire together
		burst  = (taps_mid != '0) && (CMP_W'(since_tap_n) > CMP_W'(cfg.tap_gap));
		taps_n = burst ? '0 : taps_mid;

		result.stable_level = stable_n;
		result.tap_total    = burst ? taps_mid : '0;
		if (burst)
			result.gesture = GEST_BURST;
		else if (long_hit)
			result.gesture = GEST_LONG;
		else
			result.gesture = GEST_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q    <= 1'b0;
			stable_q      <= 1'b0;
			long_rep_q    <= 1'b0;
			taps_q        <= '0;
			since_chg_q   <= '0;
			since_press_q <= '0;
			since_tap_q   <= '0;
		end else if (advance) begin
			last_raw_q    <= last_raw_n;
			stable_q      <= stable_n;
			long_rep_q    <= long_rep_n;
			taps_q        <= taps_n;
			since_chg_q   <= since_chg_n;
			since_press_q <= since_press_n;
			since_tap_q   <= since_tap_n;
		end
	end

endmodule

// File: sv/bgq_oreg.sv
module bgq_oreg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  bgq_pkg::result_t result,
	output logic             room,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata
);
	import bgq_pkg::*;

	logic    valid_q;
	result_t res_q;

	// takes a new word whenever the held one is gone or leaves this cycle
	assign room     = ~valid_q | m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = {1'b0, res_q.stable_level, res_q.tap_total, res_q.gesture};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (room) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			res_q <= result;
	end

endmodule

// File: sv/button_gesture_qualifier_unit.sv
// Button gesture qualifier. Each input word carries one raw button sample
// (one tick). The sample is debounced against debounce_ticks; a stable press
// held long_press_ticks reports a long press once and drops pending taps; a
// release that did not end a long press counts a tap (saturating at 15); once
// more than tap_gap_ticks have passed since the last tap the burst is reported
// with its count. Every input word yields exactly one output word from a
// single output register. Throughput is one word per clock: s_tready drops
// only while a result is held and m_tready is low. Elapsed counters are
// TIMER_BITS wide and hold at all ones. Registers sit on an APB port at 0x0
// (debounce), 0x4 (tap gap), 0x8 (long press), 16 bits each; write them
// only while the stream is idle.
`include "assert_macros.svh"

module button_gesture_qualifier_unit #(
	parameter int TIMER_BITS = bgq_pkg::TIMER_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// APB configuration
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [bgq_pkg::APB_AW-1:0] paddr,
	input  logic [bgq_pkg::APB_DW-1:0] pwdata,
	output logic [bgq_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	// sample stream in
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,  // [0] raw_pressed, [7:1] zero
	// gesture stream out
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [7:0]                 m_tdata   // [1:0] gesture, [5:2] tap_total,
	                                             // [6] stable_level, [7] zero
);
	import bgq_pkg::*;

	cfg_t    cfg;
	result_t result;
	logic    room;
	logic    accept;

	assign s_tready = room;
	assign accept   = s_tvalid & room;

	bgq_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// state advances only on an accepted sample
	bgq_core #(
		.TIMER_BITS (TIMER_BITS)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (accept),
		.raw     (s_tdata[0]),
		.cfg     (cfg),
		.result  (result)
	);

	bgq_oreg u_oreg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.result   (result),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// tap count is reported only with a burst event
	`BGQ_ASSERT_ALWAYS(a_total_with_burst, !m_tvalid || ((m_tdata[1:0] == GEST_BURST) == (m_tdata[5:2] != 4'd0)), "tap_total does not match gesture")

	// the input side stalls only behind a held, untaken result
	`BGQ_ASSERT_ALWAYS(a_stall_cause, s_tready || (m_tvalid && !m_tready), "input stalled without output backpressure")

	// every accepted sample shows up as a result on the next cycle
	`BGQ_ASSERT_NEXT(a_result_follows, s_tvalid && s_tready, m_tvalid, "accepted sample produced no result")

endmodule

// File: sim/testbench.sv
// Checks button_gesture_qualifier_unit against an in-bench gesture predictor.
// Every accepted sample word is run through the predictor and the predicted
// result word is queued; every accepted output word is compared field by field
// with the oldest queued prediction.
module testbench;

	import bgq_pkg::*;

	// No accepted word for this many cycles ends the run.
	localparam int STALL_LIMIT = 256;
	// Register slot past the last mapped one; writes there must be dropped.
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef logic [TIMER_BITS_DEF-1:0] timer_t;

	logic                clk     = 1'b0;
	logic                arst_n  = 1'b0;
	logic                psel    = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite  = 1'b0;
	logic [APB_AW-1:0]   paddr   = '0;
	logic [APB_DW-1:0]   pwdata  = '0;
	logic [APB_DW-1:0]   prdata;
	logic                pready;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata  = '0;   // [0] raw_pressed, [7:1] zero
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [7:0]          m_tdata;          // [1:0] gesture, [5:2] tap_total,
	                                       // [6] stable_level, [7] zero

	button_gesture_qualifier_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------------------------------------------------------------
	// Gesture predictor: register mirror plus a private copy of the state.
	// ---------------------------------------------------------------------
	logic [CFG_W-1:0] cfg_debounce   = DEBOUNCE_RST;
	logic [CFG_W-1:0] cfg_tap_gap    = TAP_GAP_RST;
	logic [CFG_W-1:0] cfg_long_press = LONG_PRESS_RST;

	logic             seen_raw    = 1'b0;
	logic             debounced   = 1'b0;
	logic             long_done   = 1'b0;
	logic [TAP_W-1:0] tap_count   = '0;
	timer_t           since_change = '0;
	timer_t           since_press  = '0;
	timer_t           since_tap    = '0;

	result_t qualified_q[$];    // predicted result words, oldest first
	result_t head;
	int      sent_samples = 0;
	int      checked_words = 0;
	int      mismatches = 0;
	bit      tx_idling = 1'b1;
	bit      rx_idling = 1'b1;
	int unsigned quiet_cycles = 0;

	function automatic timer_t bump(input timer_t v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// One tick: counters age, raw edge restarts debounce, stable level may
	// follow, then long press, then burst end (long press clears taps first,
	// so both can never fire on the same tick).
	function automatic result_t qualify_tick(input logic raw);
		result_t r;
		r.gesture      = GEST_NONE;
		r.tap_total    = '0;
		since_change = bump(since_change);
		since_press  = bump(since_press);
		since_tap    = bump(since_tap);
		if (raw != seen_raw) begin
			seen_raw     = raw;
			since_change = '0;
		end
		if (since_change >= cfg_debounce && raw != debounced) begin
			debounced = raw;
			if (debounced) begin
				since_press = '0;
				long_done   = 1'b0;
			end else if (!long_done) begin
				if (tap_count != TAP_MAX)
					tap_count = tap_count + 1'b1;
				since_tap = '0;
			end
		end
		if (debounced && !long_done && since_press >= cfg_long_press) begin
			long_done = 1'b1;
			tap_count = '0;
			r.gesture = GEST_LONG;
		end
		if (tap_count != 0 && since_tap > cfg_tap_gap) begin
			r.gesture   = GEST_BURST;
			r.tap_total = tap_count;
			tap_count   = '0;
		end
		r.stable_level = debounced;
		return r;
	endfunction

	// ---------------------------------------------------------------------
	// Stream and bus drivers. Everything is driven by NBA right after a
	// rising edge; handshakes are sampled in the active region of the edge,
	// where the block's outputs still hold their pre-edge values.
	// ---------------------------------------------------------------------
	task automatic report_mismatch(input string msg);
		$display("mismatch at output word %0d: %s", checked_words, msg);
		mismatches++;
	endtask

	// Sends one sample word. tvalid is only lowered when a gap is drawn, so
	// back-to-back words never see a low/high pair in one step.
	task automatic send_sample(input logic raw);
		int gap;
		gap = tx_idling ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'b0, raw};
		do @(posedge clk); while (!s_tready);
		qualified_q.push_back(qualify_tick(raw));
		sent_samples++;
	endtask

	task automatic hold_level(input logic level, input int n);
		repeat (n) send_sample(level);
	endtask

	task automatic chatter(input int n);
		repeat (n) send_sample(1'($urandom));
	endtask

	// LSB first: bit i is the sample of tick i.
	task automatic play_levels(input logic [31:0] bits, input int n);
		for (int i = 0; i < n; i++)
			send_sample(bits[i]);
	endtask

	// Stream goes idle and every predicted word has been taken; then the
	// output register is left to empty.
	task automatic settle();
		s_tvalid <= 1'b0;
		wait (qualified_q.size() == 0);
		repeat (2) @(posedge clk);
	endtask

	// Setup phase, access phase, then an idle phase so the next write starts clean.
	// Upper data bits carry junk; only the low 16 bits belong to a register.
	task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'($urandom), val};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_DEBOUNCE:   cfg_debounce   = val;
			REG_TAP_GAP:    cfg_tap_gap    = val;
			REG_LONG_PRESS: cfg_long_press = val;
			default: ;
		endcase
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] gap,
			input logic [CFG_W-1:0] lng);
		settle();
		write_reg(REG_DEBOUNCE, deb);
		write_reg(REG_TAP_GAP, gap);
		write_reg(REG_LONG_PRESS, lng);
	endtask

	function automatic int clip(input int v);
		return (v > 64) ? 64 : v;
	endfunction

	// One random but well-formed gesture, durations scaled to the current
	// settings (huge settings are clipped so the run stays short).
	task automatic play_gesture();
		int kind, taps, d, g, l;
		d = clip(cfg_debounce);
		g = clip(cfg_tap_gap);
		l = clip(cfg_long_press);
		kind = $urandom_range(0, 9);
		if (kind <= 5) begin
			// tap burst; about one in four is long (14 to 20 taps) and may run past the 15-tap ceiling
			taps = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 4);
			repeat (taps) begin
				chatter($urandom_range(0, (d > 0) ? d - 1 : 0));
				hold_level(1'b1, d + 1 + $urandom_range(0, (l > 1) ? l - 1 : 0));
				chatter($urandom_range(0, (d > 0) ? d - 1 : 0));
				hold_level(1'b0, d + 1 + $urandom_range(0, g / 2));
			end
			hold_level(1'b0, g + 2 + $urandom_range(0, 3));
		end else if (kind <= 7) begin
			// long press, on the 7 path preceded by a tap it must discard
			if (kind == 7) begin
				hold_level(1'b1, d + 1);
				hold_level(1'b0, d + 1);
			end
			hold_level(1'b1, d + l + $urandom_range(0, 4));
			hold_level(1'b0, d + 1 + $urandom_range(0, 4));
		end else begin
			chatter($urandom_range(1, 12));
		end
	endtask

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Zero debounce: edges are taken on the same tick; two quick taps then a
	// burst of two once the gap has passed.
	task automatic test_zero_debounce();
		configure(16'd0, 16'd1, 16'd3);
		play_levels(32'b0000101, 7);
	endtask

	// A write past the register map must not change any setting.
	task automatic test_unmapped_register();
		settle();
		write_reg(REG_UNUSED, 16'hFFFF);
		play_levels(32'b0001, 4);
	endtask

	// Zero long-press time: the press is long at once, its release is no tap.
	task automatic test_zero_long_press();
		configure(16'd0, 16'd1, 16'd0);
		play_levels(32'b00011, 5);
	endtask

	// Bounces shorter than the debounce time are filtered.
	task automatic test_chatter();
		configure(16'd2, 16'd3, 16'd6);
		play_levels(32'b00000010111101, 14);
	endtask

	// All settings at the top of the range: a short run of holds and bounces
	// never gets past any threshold.
	task automatic test_huge_settings();
		configure(16'hFFFF, 16'hFFFF, 16'hFFFF);
		hold_level(1'b1, 40);
		chatter(40);
		hold_level(1'b0, 20);
	endtask

	task automatic test_random_gestures(input logic [CFG_W-1:0] deb,
			input logic [CFG_W-1:0] gap, input logic [CFG_W-1:0] lng,
			input int n, input bit tx_idle, input bit rx_idle);
		int stop;
		configure(deb, gap, lng);
		tx_idling = tx_idle;
		rx_idling = rx_idle;
		stop = sent_samples + n;
		while (sent_samples < stop)
			play_gesture();
		tx_idling = 1'b1;
		rx_idling = 1'b1;
	endtask

	// ---------------------------------------------------------------------
	// Output side: random stall before each word when rx_idling is set, then compare.
	// ---------------------------------------------------------------------
	initial begin
		int stall;
		wait (arst_n);
		forever begin
			stall = rx_idling ? $urandom_range(0, 4) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (qualified_q.size() == 0) begin
				report_mismatch($sformatf("word 0x%02h with no prediction pending", m_tdata));
			end else begin
				head = qualified_q.pop_front();
				if (m_tdata[1:0] !== head.gesture)
					report_mismatch($sformatf("gesture %0d, predicted %0d",
						m_tdata[1:0], head.gesture));
				if (m_tdata[5:2] !== head.tap_total)
					report_mismatch($sformatf("tap_total %0d, predicted %0d",
						m_tdata[5:2], head.tap_total));
				if (m_tdata[6] !== head.stable_level)
					report_mismatch($sformatf("stable_level %0d, predicted %0d",
						m_tdata[6], head.stable_level));
			end
			checked_words++;
		end
	end

	// Watchdog: any accepted word on either side restarts the count.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= STALL_LIMIT);
		$display("Verification failed");
		$finish;
	end

	// ---------------------------------------------------------------------
	// Sequence of tests
	// ---------------------------------------------------------------------
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zero_debounce();
		test_unmapped_register();
		test_zero_long_press();
		test_chatter();

		test_random_gestures(16'd0, 16'($urandom_range(8, 30)),
			16'($urandom_range(4, 20)), 200, 1'b1, 1'b1);
		// long gap against short taps: the longest bursts run into the 15-tap ceiling
		test_random_gestures(16'd1, 16'd60, 16'd20, 250, 1'b1, 1'b0);
		test_random_gestures(16'($urandom_range(1, 4)), 16'($urandom_range(0, 20)),
			16'($urandom_range(5, 40)), 200, 1'b0, 1'b1);
		test_random_gestures(16'd0, 16'd0, 16'd0, 100, 1'b1, 1'b1);
		test_huge_settings();
		test_random_gestures(16'($urandom_range(0, 3)), 16'($urandom_range(0, 3)),
			16'($urandom_range(1, 8)), 150, 1'b1, 1'b1);
		test_random_gestures(DEBOUNCE_RST, TAP_GAP_RST, LONG_PRESS_RST, 100, 1'b1, 1'b1);

		settle();
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: sim.f
+incdir+sv
sv/bgq_pkg.sv
sv/bgq_cfg.sv
sv/bgq_core.sv
sv/bgq_oreg.sv
sv/button_gesture_qualifier_unit.sv
sim/testbench.sv
